[rtl/bpfm_pkg.sv]
// ----------------------------------------------------------------------------
// bpfm_pkg: shared types and constants of the band projection feature matcher
// Register map, controller states and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_ROW_THRESH   = 3'd1;
  localparam logic [2:0] REG_REF_ENERGY   = 3'd2;
  localparam logic [2:0] REG_REF_COL_CENT = 3'd3;
  localparam logic [2:0] REG_REF_ROW_CENT = 3'd4;
  localparam logic [2:0] REG_REF_PEAK_COL = 3'd5;
  localparam logic [2:0] REG_REF_PEAK_ROW = 3'd6;

  localparam logic [10:0] RST_IMAGE_WIDTH = 11'd1024;
  localparam logic [17:0] RST_ROW_THRESH  = 18'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_ACC,
    ST_ACC_END,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_LOAD
  } bpfm_state_t;

  typedef struct packed {
    logic take_pixel;
    logic row_eval;
    logic walk_clr;
    logic acc_step;
    logic scan_step;
    logic clear_step;
    logic div_start_col;
    logic div_start_row;
    logic div_step;
    logic cap_col;
    logic cap_row;
    logic load_out;
    logic finish;
  } bpfm_cmd_t;

  typedef struct packed {
    logic row_end;
    logic incl;
    logic emit;
    logic band_done;
    logic acc_last;
    logic all_last;
    logic div_done;
    logic out_free;
  } bpfm_sts_t;

endpackage

[rtl/band_projection_feature_matcher_core.sv]
// ----------------------------------------------------------------------------
// band_projection_feature_matcher_core: spectrogram band feature matcher
// Sequence: at each row end the row is decided; a row that joins a band is then
//   added into the column sums over its len columns; a closing band adds a scan
//   of all columns and two divisions of DW-bit moments, then the load.
// Throughput: 1 pixel per cycle inside a row; in_stall holds intake at each row end.
// Reset: synchronous; a sweep zeroes all MAX_WIDTH column sums; no pixel is taken.
// ----------------------------------------------------------------------------
module band_projection_feature_matcher_core
  import bpfm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  input  logic        in_end_of_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_band_index,
  output logic [9:0]  out_start_row,
  output logic [9:0]  out_end_row,
  output logic [27:0] out_energy,
  output logic [9:0]  out_col_centroid,
  output logic [9:0]  out_row_centroid,
  output logic [9:0]  out_peak_col,
  output logic [9:0]  out_peak_row,
  output logic [27:0] out_distance,
  output logic        out_closed_at_frame_end
);

  logic [10:0] image_width_r;
  logic [17:0] row_threshold_r;
  logic [27:0] ref_energy_r;
  logic [9:0]  ref_col_centroid_r;
  logic [9:0]  ref_row_centroid_r;
  logic [9:0]  ref_peak_col_r;
  logic [9:0]  ref_peak_row_r;
  logic [2:0]  reg_idx;
  logic        wr_en;
  bpfm_cmd_t   cmd;
  bpfm_sts_t   sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r      <= RST_IMAGE_WIDTH;
      row_threshold_r    <= RST_ROW_THRESH;
      ref_energy_r       <= '0;
      ref_col_centroid_r <= '0;
      ref_row_centroid_r <= '0;
      ref_peak_col_r     <= '0;
      ref_peak_row_r     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  image_width_r      <= pwdata[10:0];
        REG_ROW_THRESH:   row_threshold_r    <= pwdata[17:0];
        REG_REF_ENERGY:   ref_energy_r       <= pwdata[27:0];
        REG_REF_COL_CENT: ref_col_centroid_r <= pwdata[9:0];
        REG_REF_ROW_CENT: ref_row_centroid_r <= pwdata[9:0];
        REG_REF_PEAK_COL: ref_peak_col_r     <= pwdata[9:0];
        REG_REF_PEAK_ROW: ref_peak_row_r     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(image_width_r);
      REG_ROW_THRESH:   prdata = 32'(row_threshold_r);
      REG_REF_ENERGY:   prdata = 32'(ref_energy_r);
      REG_REF_COL_CENT: prdata = 32'(ref_col_centroid_r);
      REG_REF_ROW_CENT: prdata = 32'(ref_row_centroid_r);
      REG_REF_PEAK_COL: prdata = 32'(ref_peak_col_r);
      REG_REF_PEAK_ROW: prdata = 32'(ref_peak_row_r);
      default:          prdata = '0;
    endcase
  end

  bpfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpfm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_image_width         (image_width_r),
    .cfg_row_threshold       (row_threshold_r),
    .cfg_ref_energy          (ref_energy_r),
    .cfg_ref_col_centroid    (ref_col_centroid_r),
    .cfg_ref_row_centroid    (ref_row_centroid_r),
    .cfg_ref_peak_col        (ref_peak_col_r),
    .cfg_ref_peak_row        (ref_peak_row_r),
    .in_pixel                (in_pixel),
    .in_end_of_image         (in_end_of_image),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .out_band_index          (out_band_index),
    .out_start_row           (out_start_row),
    .out_end_row             (out_end_row),
    .out_energy              (out_energy),
    .out_col_centroid        (out_col_centroid),
    .out_row_centroid        (out_row_centroid),
    .out_peak_col            (out_peak_col),
    .out_peak_row            (out_peak_row),
    .out_distance            (out_distance),
    .out_closed_at_frame_end (out_closed_at_frame_end)
  );

endmodule

[rtl/bpfm_ctrl.sv]
// ----------------------------------------------------------------------------
// bpfm_ctrl: sequencer of the band projection feature matcher
// Steps pixel intake, row decision, column walks, divisions and result load.
// ----------------------------------------------------------------------------
module bpfm_ctrl
  import bpfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bpfm_sts_t sts,
  output bpfm_cmd_t cmd
);

  bpfm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.all_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && sts.row_end) state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (sts.incl) state_nxt = ST_ACC;
        else if (sts.emit) state_nxt = ST_SCAN;
        else state_nxt = ST_IDLE;
      end
      ST_ACC: begin
        if (sts.acc_last) state_nxt = ST_ACC_END;
      end
      ST_ACC_END: begin
        state_nxt = sts.band_done ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.all_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_nxt = ST_DIV_COL;
      end
      ST_DIV_COL: begin
        if (sts.div_done) state_nxt = ST_DIV_ROW;
      end
      ST_DIV_ROW: begin
        if (sts.div_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.take_pixel = in_valid;
      end
      ST_ROW: begin
        cmd.row_eval = 1'b1;
        cmd.walk_clr = 1'b1;
        cmd.finish   = !sts.incl && !sts.emit;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
      end
      ST_ACC_END: begin
        cmd.walk_clr = 1'b1;
        cmd.finish   = !sts.band_done;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_SCAN_END: begin
        cmd.div_start_col = 1'b1;
      end
      ST_DIV_COL: begin
        cmd.div_step      = !sts.div_done;
        cmd.cap_col       = sts.div_done;
        cmd.div_start_row = sts.div_done;
      end
      ST_DIV_ROW: begin
        cmd.div_step = !sts.div_done;
        cmd.cap_row  = sts.div_done;
      end
      ST_LOAD: begin
        cmd.load_out = sts.out_free;
        cmd.finish   = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/bpfm_datapath.sv]
// ----------------------------------------------------------------------------
// bpfm_datapath: accumulators, line memories, divider and result register
// Row folds, band column projection, argmax scan and centroid division.
// ----------------------------------------------------------------------------
module bpfm_datapath
  import bpfm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  bpfm_cmd_t   cmd,
  output bpfm_sts_t   sts,
  input  logic [10:0] cfg_image_width,
  input  logic [17:0] cfg_row_threshold,
  input  logic [27:0] cfg_ref_energy,
  input  logic [9:0]  cfg_ref_col_centroid,
  input  logic [9:0]  cfg_ref_row_centroid,
  input  logic [9:0]  cfg_ref_peak_col,
  input  logic [9:0]  cfg_ref_peak_row,
  input  logic [7:0]  in_pixel,
  input  logic        in_end_of_image,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [8:0]  out_band_index,
  output logic [9:0]  out_start_row,
  output logic [9:0]  out_end_row,
  output logic [27:0] out_energy,
  output logic [9:0]  out_col_centroid,
  output logic [9:0]  out_row_centroid,
  output logic [9:0]  out_peak_col,
  output logic [9:0]  out_peak_row,
  output logic [27:0] out_distance,
  output logic        out_closed_at_frame_end
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int TW  = 8 + XW;
  localparam int MW  = 8 + 2 * XW;
  localparam int EW  = 8 + XW + YW;
  localparam int DW  = EW + ((XW > YW) ? XW : YW);
  localparam int CSW = 8 + YW;
  localparam int NW  = $clog2(DW + 1);

  logic [7:0]     pend_mem [MAX_WIDTH];
  logic [CSW-1:0] cs_mem   [MAX_WIDTH];

  logic [XW-1:0]  col_r;
  logic [XW:0]    len_r;
  logic [YW:0]    row_r;
  logic           in_band_r;
  logic [8:0]     band_cnt_r;
  logic [YW-1:0]  band_start_r;
  logic [TW-1:0]  row_total_r;
  logic [MW-1:0]  row_mom_r;
  logic [EW-1:0]  energy_r;
  logic [DW-1:0]  col_mom_r;
  logic [DW-1:0]  rmom_r;
  logic [TW-1:0]  best_sum_r;
  logic [YW-1:0]  best_row_r;
  logic           eoi_r;
  logic           emit_r;
  logic           forced_r;
  logic [YW-1:0]  end_row_r;

  logic [XW-1:0]  widx_r;
  logic [XW-1:0]  wadr_r;
  logic           avld_r;
  logic           svld_r;
  logic [CSW-1:0] cs_rd_r;
  logic [7:0]     pd_rd_r;
  logic [CSW-1:0] best_cs_r;
  logic [XW-1:0]  pc_r;

  logic [EW:0]    rem_r;
  logic [DW-1:0]  quo_r;
  logic [NW-1:0]  dcnt_r;
  logic [9:0]     cc_r;
  logic [9:0]     rc_r;

  logic           out_valid_r;
  logic [8:0]     o_band_r;
  logic [9:0]     o_start_r, o_end_r, o_cc_r, o_rc_r, o_pc_r, o_pr_r;
  logic [27:0]    o_energy_r, o_dist_r;
  logic           o_forced_r;

  logic [12:0]    iw_ext, w_eff;
  logic           row_end;
  logic           row_ok, opening, below, incl, close_c, emit_c, emit_now;
  logic [MW-1:0]  pix_mom;
  logic [DW-1:0]  row_term;
  logic           cs_we;
  logic [XW-1:0]  cs_wa;
  logic [CSW-1:0] cs_wd;
  logic [EW:0]    rem_sh;
  logic           rem_ge;
  logic [27:0]    e28;
  logic [29:0]    dist_sum;

  function automatic logic [27:0] absdiff(input logic [27:0] a, input logic [27:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  // effective row length
  always_comb begin
    iw_ext = 13'(cfg_image_width);
    if (iw_ext == 13'd0) begin
      w_eff = 13'd1;
    end else if (iw_ext > 13'(MAX_WIDTH)) begin
      w_eff = 13'(MAX_WIDTH);
    end else begin
      w_eff = iw_ext;
    end
    row_end = in_end_of_image || ((13'(col_r) + 13'd1) >= w_eff);
    pix_mom = MW'(in_pixel) * MW'(col_r);
  end

  // row decision
  always_comb begin
    row_ok   = row_r < (YW+1)'(MAX_HEIGHT);
    opening  = row_ok && !in_band_r && (32'(row_total_r) > 32'(cfg_row_threshold));
    below    = 32'(row_total_r) < 32'(cfg_row_threshold);
    incl     = row_ok && (in_band_r || opening);
    close_c  = row_ok && in_band_r && below;
    emit_c   = row_ok ? (close_c || (eoi_r && (in_band_r || opening)))
                      : (eoi_r && in_band_r);
    emit_now = cmd.row_eval ? emit_c : emit_r;
    row_term = DW'(row_total_r) * DW'(row_r[YW-1:0]);
  end

  assign sts.row_end   = row_end;
  assign sts.incl      = incl;
  assign sts.emit      = emit_c;
  assign sts.band_done = emit_r;
  assign sts.acc_last  = ((XW+1)'(widx_r) + (XW+1)'(1)) == len_r;
  assign sts.all_last  = widx_r == XW'(MAX_WIDTH - 1);
  assign sts.div_done  = dcnt_r == NW'(DW);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // band and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      in_band_r   <= 1'b0;
      band_cnt_r  <= '0;
      row_total_r <= '0;
      row_mom_r   <= '0;
      emit_r      <= 1'b0;
    end else begin
      if (cmd.take_pixel) begin
        row_total_r <= row_total_r + TW'(in_pixel);
        row_mom_r   <= row_mom_r + pix_mom;
        if (row_end) begin
          col_r <= '0;
          len_r <= (XW+1)'(col_r) + (XW+1)'(1);
        end else begin
          col_r <= col_r + XW'(1);
        end
      end
      if (cmd.row_eval) begin
        row_total_r <= '0;
        row_mom_r   <= '0;
        emit_r      <= emit_c;
      end
      if (cmd.finish && eoi_r) begin
        band_cnt_r <= '0;
        row_r      <= '0;
        in_band_r  <= 1'b0;
      end else begin
        if (cmd.row_eval) begin
          if (row_ok) row_r <= row_r + (YW+1)'(1);
          if (emit_c) in_band_r <= 1'b0;
          else if (opening) in_band_r <= 1'b1;
        end
        if (cmd.finish && emit_now) band_cnt_r <= band_cnt_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) eoi_r <= in_end_of_image;
    if (cmd.row_eval) begin
      forced_r  <= !close_c;
      end_row_r <= row_ok ? row_r[YW-1:0] : YW'(MAX_HEIGHT - 1);
      if (opening) band_start_r <= row_r[YW-1:0];
      if (incl) begin
        energy_r  <= (opening ? '0 : energy_r) + EW'(row_total_r);
        col_mom_r <= (opening ? '0 : col_mom_r) + DW'(row_mom_r);
        rmom_r    <= (opening ? '0 : rmom_r) + row_term;
        if (opening || (row_total_r > best_sum_r)) begin
          best_sum_r <= row_total_r;
          best_row_r <= row_r[YW-1:0];
        end
      end
    end
  end

  // column walks
  always_comb begin
    cs_we = avld_r || cmd.scan_step || cmd.clear_step;
    cs_wa = avld_r ? wadr_r : widx_r;
    cs_wd = avld_r ? cs_rd_r + CSW'(pd_rd_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      avld_r <= 1'b0;
      svld_r <= 1'b0;
    end else begin
      avld_r <= cmd.acc_step;
      svld_r <= cmd.scan_step;
      if (cmd.walk_clr) begin
        widx_r <= '0;
      end else if (cmd.acc_step || cmd.scan_step || cmd.clear_step) begin
        widx_r <= widx_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) pend_mem[col_r] <= in_pixel;
    if (cs_we) cs_mem[cs_wa] <= cs_wd;
    cs_rd_r <= cs_mem[widx_r];
    pd_rd_r <= pend_mem[widx_r];
    wadr_r  <= widx_r;
    if (cmd.walk_clr) begin
      best_cs_r <= '0;
      pc_r      <= '0;
    end else if (svld_r && (cs_rd_r > best_cs_r)) begin
      best_cs_r <= cs_rd_r;
      pc_r      <= wadr_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r[EW-1:0], quo_r[DW-1]};
    rem_ge = rem_sh >= {1'b0, energy_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_col || cmd.div_start_row) begin
      rem_r  <= '0;
      quo_r  <= cmd.div_start_row ? rmom_r : col_mom_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_sh - {1'b0, energy_r} : rem_sh;
      quo_r  <= {quo_r[DW-2:0], rem_ge};
      dcnt_r <= dcnt_r + NW'(1);
    end
    if (cmd.cap_col) cc_r <= (energy_r == '0) ? 10'd0 : quo_r[9:0];
    if (cmd.cap_row) rc_r <= (energy_r == '0) ? 10'd0 : quo_r[9:0];
  end

  // result register
  always_comb begin
    e28      = 28'(energy_r);
    dist_sum = 30'(absdiff(cfg_ref_energy, e28))
             + 30'(absdiff(28'(cfg_ref_col_centroid), 28'(cc_r)))
             + 30'(absdiff(28'(cfg_ref_row_centroid), 28'(rc_r)))
             + 30'(absdiff(28'(cfg_ref_peak_col), 28'(10'(pc_r))))
             + 30'(absdiff(28'(cfg_ref_peak_row), 28'(10'(best_row_r))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_band_r   <= band_cnt_r;
      o_start_r  <= 10'(band_start_r);
      o_end_r    <= 10'(end_row_r);
      o_energy_r <= e28;
      o_cc_r     <= cc_r;
      o_rc_r     <= rc_r;
      o_pc_r     <= 10'(pc_r);
      o_pr_r     <= 10'(best_row_r);
      o_dist_r   <= dist_sum[27:0];
      o_forced_r <= forced_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_band_index          = o_band_r;
  assign out_start_row           = o_start_r;
  assign out_end_row             = o_end_r;
  assign out_energy              = o_energy_r;
  assign out_col_centroid        = o_cc_r;
  assign out_row_centroid        = o_rc_r;
  assign out_peak_col            = o_pc_r;
  assign out_peak_row            = o_pr_r;
  assign out_distance            = o_dist_r;
  assign out_closed_at_frame_end = o_forced_r;

endmodule
